[hdl/vaaq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaaq_pkg
// Shared widths, constants and the arctangent table of the attitude block.
// ----------------------------------------------------------------------------
package vaaq_pkg;

  localparam int CordicStagesDefault = 30;
  localparam int VelW = 32;
  localparam int QW = 32;
  // internal cordic word: Q6.30, angles up to about 2*pi plus growth
  localparam int CW = 36;

  localparam logic signed [CW-1:0] Q30One  = 36'sd1073741824;
  localparam logic signed [CW-1:0] Q30Pi   = 36'sd3373259426;
  localparam logic signed [CW-1:0] Q30InvK = 36'sd652032874;

  typedef logic signed [CW-1:0] cw_t;

  // arctangent of 2^-i in Q2.30, truncated
  function automatic cw_t atan_q30(input int i);
    cw_t r;
    r = '0;
    case (i)
      0: r = 36'sd843314856;
      1: r = 36'sd497837829;
      2: r = 36'sd263043836;
      3: r = 36'sd133525158;
      4: r = 36'sd67021686;
      5: r = 36'sd33543515;
      6: r = 36'sd16775850;
      7: r = 36'sd8388437;
      8: r = 36'sd4194282;
      9: r = 36'sd2097149;
      10: r = 36'sd1048575;
      default: begin
        if (i <= 30) r = (cw_t'(1) <<< (30 - i)) - cw_t'(1);
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

[hdl/vaaq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaaq_in_if / vaaq_out_if
// Valid/ready channels for velocity pairs and quaternion results.
// ----------------------------------------------------------------------------
interface vaaq_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] payload_vel_x;
  logic signed [31:0] payload_vel_y;
  logic signed [31:0] payload_vel_z;
  logic signed [31:0] wind_vel_x;
  logic signed [31:0] wind_vel_y;
  logic signed [31:0] wind_vel_z;
  modport source (output valid, payload_vel_x, payload_vel_y, payload_vel_z,
                  wind_vel_x, wind_vel_y, wind_vel_z, input ready);
  modport sink (input valid, payload_vel_x, payload_vel_y, payload_vel_z,
                wind_vel_x, wind_vel_y, wind_vel_z, output ready);
endinterface

interface vaaq_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic degenerate;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, degenerate,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, degenerate,
                output ready);
endinterface

[hdl/velocity_aligned_attitude_quaternion_top.sv]
`timescale 1ns / 1ps
// register stages from input transaction to result: three front stages, three cordic
// chains, length stage, clamp, products, output
// throughput: one transaction per cycle unless stalled (fully pipelined cordic chains)
// a stall on the output holds the whole pipeline in place; nothing is dropped
// reset (rst, synchronous) clears all stage valid bits; data registers keep
// their contents
// ----------------------------------------------------------------------------
// velocity_aligned_attitude_quaternion_top
// Relative velocity to zero-roll attitude quaternion through cordic pipelines.
// ----------------------------------------------------------------------------
module velocity_aligned_attitude_quaternion_top #(
  parameter int CORDIC_STAGES = vaaq_pkg::CordicStagesDefault
) (
  input  logic clk,
  input  logic rst,
  vaaq_in_if.sink    in_ch,
  vaaq_out_if.source out_ch
);

  localparam int N = CORDIC_STAGES;
  localparam int CW = vaaq_pkg::CW;

  typedef logic signed [CW-1:0] w_t;

  // global advance: whole pipeline moves when output slot is free
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage A: differences ----------------
  logic a_v, a_deg;
  logic signed [33:0] a_dx, a_dy, a_dz;
  logic [33:0] a_m;

  logic signed [33:0] dxn, dyn, dzn;
  logic [33:0] mxn, myn, mzn, mn;
  always_comb begin
    dxn = 34'(in_ch.payload_vel_x) - 34'(in_ch.wind_vel_x);
    dyn = 34'(in_ch.payload_vel_y) - 34'(in_ch.wind_vel_y);
    dzn = 34'(in_ch.payload_vel_z) - 34'(in_ch.wind_vel_z);
    mxn = dxn[33] ? 34'(-dxn) : 34'(dxn);
    myn = dyn[33] ? 34'(-dyn) : 34'(dyn);
    mzn = dzn[33] ? 34'(-dzn) : 34'(dzn);
    mn = mxn;
    if (myn > mn) mn = myn;
    if (mzn > mn) mn = mzn;
  end

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= in_ch.valid;
    if (adv) begin
      a_dx <= dxn; a_dy <= dyn; a_dz <= dzn; a_m <= mn;
      a_deg <= (dxn == '0) && (dyn == '0) && (dzn == '0);
    end
  end

  // ---------------- stage B: leading bit and normalize ----------------
  logic b_v, b_deg;
  w_t b_dx, b_dy, b_dz;

  // shift amount: positive = right, negative = left, m in [2^29, 2^30)
  logic signed [6:0] sh;
  always_comb begin
    sh = '0;
    for (int k = 0; k < 34; k++) begin
      if (a_m[k]) sh = 7'(k - 29);
    end
  end

  function automatic w_t norm(input logic signed [33:0] v, input logic signed [6:0] s);
    logic signed [63:0] e;
    e = 64'(v);
    if (s >= 0) e = e >>> s;
    else e = e <<< (-s);
    return CW'(e);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (adv) b_v <= a_v;
    if (adv) begin
      b_deg <= a_deg;
      b_dx <= norm(a_dx, sh);
      b_dy <= norm(a_dy, sh);
      b_dz <= norm(a_dz, sh);
    end
  end

  // ---------------- stage C: pitch vectoring setup ----------------
  logic c_v, c_deg, c_bz;
  w_t c_a, c_b, c_z, c_dy;
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (adv) c_v <= b_v;
    if (adv) begin
      c_deg <= b_deg;
      c_dy <= b_dy;
      c_bz <= (b_dz == '0);
      if (b_dz == '0) begin
        // x-only: pitch and h are direct
        c_a <= -b_dx;
        c_b <= '0;
        c_z <= (-b_dx > 0) ? w_t'(0) : -vaaq_pkg::Q30Pi;
      end else if (-b_dx < 0) begin
        c_a <= b_dx;
        c_b <= b_dz;
        c_z <= (-b_dz > 0) ? vaaq_pkg::Q30Pi : -vaaq_pkg::Q30Pi;
      end else begin
        c_a <= -b_dx;
        c_b <= -b_dz;
        c_z <= '0;
      end
    end
  end

  // ---------------- pitch vectoring pipeline ----------------
  w_t pv_x [N+1], pv_y [N+1], pv_z [N+1], pv_dy [N+1];
  logic pv_v [N+1], pv_deg [N+1], pv_bz [N+1];
  assign pv_x[0] = c_a; assign pv_y[0] = c_b; assign pv_z[0] = c_z;
  assign pv_dy[0] = c_dy; assign pv_v[0] = c_v; assign pv_deg[0] = c_deg;
  assign pv_bz[0] = c_bz;

  for (genvar i = 0; i < N; i++) begin : g_pv
    always_ff @(posedge clk) begin
      if (rst) pv_v[i+1] <= 1'b0;
      else if (adv) pv_v[i+1] <= pv_v[i];
      if (adv) begin
        pv_deg[i+1] <= pv_deg[i];
        pv_bz[i+1] <= pv_bz[i];
        pv_dy[i+1] <= pv_dy[i];
        if (pv_bz[i]) begin
          pv_x[i+1] <= pv_x[i]; pv_y[i+1] <= pv_y[i]; pv_z[i+1] <= pv_z[i];
        end else if (pv_y[i] >= 0) begin
          pv_x[i+1] <= pv_x[i] + (pv_y[i] >>> i);
          pv_y[i+1] <= pv_y[i] - (pv_x[i] >>> i);
          pv_z[i+1] <= pv_z[i] + vaaq_pkg::atan_q30(i);
        end else begin
          pv_x[i+1] <= pv_x[i] - (pv_y[i] >>> i);
          pv_y[i+1] <= pv_y[i] + (pv_x[i] >>> i);
          pv_z[i+1] <= pv_z[i] - vaaq_pkg::atan_q30(i);
        end
      end
    end
  end

  // ---------------- stage D: horizontal length ----------------
  logic d_v, d_deg;
  w_t d_h, d_pitch, d_dy;
  logic signed [CW+31:0] hprod;
  w_t hs, habs;
  always_comb begin
    hprod = (CW+32)'(pv_x[N]) * (CW+32)'(vaaq_pkg::Q30InvK);
    hs = CW'(hprod >>> 30);
    habs = pv_x[N][CW-1] ? -pv_x[N] : pv_x[N];
  end
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (adv) d_v <= pv_v[N];
    if (adv) begin
      d_deg <= pv_deg[N];
      d_pitch <= pv_z[N];
      d_dy <= pv_dy[N];
      if (pv_bz[N]) d_h <= habs;
      else d_h <= (hs < 0) ? w_t'(0) : hs;
    end
  end

  // ---------------- yaw vectoring pipeline ----------------
  w_t yv_x [N+1], yv_y [N+1], yv_z [N+1], yv_p [N+1];
  logic yv_v [N+1], yv_deg [N+1];
  assign yv_x[0] = d_h; assign yv_y[0] = d_dy; assign yv_z[0] = '0;
  assign yv_p[0] = d_pitch; assign yv_v[0] = d_v; assign yv_deg[0] = d_deg;

  for (genvar i = 0; i < N; i++) begin : g_yv
    always_ff @(posedge clk) begin
      if (rst) yv_v[i+1] <= 1'b0;
      else if (adv) yv_v[i+1] <= yv_v[i];
      if (adv) begin
        yv_deg[i+1] <= yv_deg[i];
        yv_p[i+1] <= yv_p[i];
        if (yv_y[i] >= 0) begin
          yv_x[i+1] <= yv_x[i] + (yv_y[i] >>> i);
          yv_y[i+1] <= yv_y[i] - (yv_x[i] >>> i);
          yv_z[i+1] <= yv_z[i] + vaaq_pkg::atan_q30(i);
        end else begin
          yv_x[i+1] <= yv_x[i] - (yv_y[i] >>> i);
          yv_y[i+1] <= yv_y[i] + (yv_x[i] >>> i);
          yv_z[i+1] <= yv_z[i] - vaaq_pkg::atan_q30(i);
        end
      end
    end
  end

  // ---------------- dual rotation pipeline (pitch and yaw half angles) ------
  w_t rp_x [N+1], rp_y [N+1], rp_z [N+1];
  w_t ry_x [N+1], ry_y [N+1], ry_z [N+1];
  logic r_v [N+1], r_deg [N+1];
  assign rp_x[0] = vaaq_pkg::Q30InvK; assign rp_y[0] = '0;
  assign rp_z[0] = yv_p[N] >>> 1;
  assign ry_x[0] = vaaq_pkg::Q30InvK; assign ry_y[0] = '0;
  assign ry_z[0] = yv_z[N] >>> 1;
  assign r_v[0] = yv_v[N]; assign r_deg[0] = yv_deg[N];

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) r_v[i+1] <= 1'b0;
      else if (adv) r_v[i+1] <= r_v[i];
      if (adv) begin
        r_deg[i+1] <= r_deg[i];
        if (rp_z[i] >= 0) begin
          rp_x[i+1] <= rp_x[i] - (rp_y[i] >>> i);
          rp_y[i+1] <= rp_y[i] + (rp_x[i] >>> i);
          rp_z[i+1] <= rp_z[i] - vaaq_pkg::atan_q30(i);
        end else begin
          rp_x[i+1] <= rp_x[i] + (rp_y[i] >>> i);
          rp_y[i+1] <= rp_y[i] - (rp_x[i] >>> i);
          rp_z[i+1] <= rp_z[i] + vaaq_pkg::atan_q30(i);
        end
        if (ry_z[i] >= 0) begin
          ry_x[i+1] <= ry_x[i] - (ry_y[i] >>> i);
          ry_y[i+1] <= ry_y[i] + (ry_x[i] >>> i);
          ry_z[i+1] <= ry_z[i] - vaaq_pkg::atan_q30(i);
        end else begin
          ry_x[i+1] <= ry_x[i] + (ry_y[i] >>> i);
          ry_y[i+1] <= ry_y[i] - (ry_x[i] >>> i);
          ry_z[i+1] <= ry_z[i] + vaaq_pkg::atan_q30(i);
        end
      end
    end
  end

  // ---------------- stage E: clamp ----------------
  function automatic logic signed [31:0] clampu(input w_t v);
    if (v > vaaq_pkg::Q30One) return 32'sd1073741824;
    if (v < -vaaq_pkg::Q30One) return -32'sd1073741824;
    return 32'(v);
  endfunction

  logic e_v, e_deg;
  logic signed [31:0] e_cp, e_sp, e_cy, e_sy;
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (adv) e_v <= r_v[N];
    if (adv) begin
      e_deg <= r_deg[N];
      e_cp <= clampu(rp_x[N]); e_sp <= clampu(rp_y[N]);
      e_cy <= clampu(ry_x[N]); e_sy <= clampu(ry_y[N]);
    end
  end

  // ---------------- stage F: products ----------------
  logic f_v, f_deg;
  logic signed [63:0] f_w, f_x, f_y, f_z;
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (adv) f_v <= e_v;
    if (adv) begin
      f_deg <= e_deg;
      f_w <= 64'(e_cy) * 64'(e_cp);
      f_x <= 64'(e_sy) * 64'(e_sp);
      f_y <= 64'(e_cy) * 64'(e_sp);
      f_z <= 64'(e_sy) * 64'(e_cp);
    end
  end

  // ---------------- output register: rounding and identity case ----------
  function automatic logic signed [31:0] rnd(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return 32'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (adv) out_ch.valid <= f_v;
    if (adv) begin
      out_ch.degenerate <= f_deg;
      if (f_deg) begin
        out_ch.quat_w <= 32'sd1073741824;
        out_ch.quat_x <= '0; out_ch.quat_y <= '0; out_ch.quat_z <= '0;
      end else begin
        out_ch.quat_w <= rnd(f_w);
        out_ch.quat_x <= -rnd(f_x);
        out_ch.quat_y <= rnd(f_y);
        out_ch.quat_z <= rnd(f_z);
      end
    end
  end

endmodule
